>>> hw/rtl/srl_pkg.sv
package srl_pkg;

  // Block configuration.
  localparam int SAMPLE_STRIDE = 1;
  localparam int MAX_FRAMES    = 65536;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int FULL_SCALE = 32768;

  // A squared Q1.15 magnitude is at most 2^30, so it needs 31 bits.
  localparam int SQ_W      = 2 * SAMPLE_W - 1;
  localparam int FRAME_W   = $clog2(MAX_FRAMES + 1);
  localparam int PHASE_W   = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
  localparam int STRIDE_W  = $clog2(SAMPLE_STRIDE + 1);
  localparam int SUM_W     = SQ_W + FRAME_W - 1;

  // Divide and root datapath.
  localparam int DIVIDEND_W = SUM_W + STRIDE_W;
  localparam int ROOT_W     = (DIVIDEND_W + 1) / 2;
  localparam int QUO_W      = 2 * ROOT_W;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam int DIV_REM_W  = FRAME_W + 1;
  localparam int SQ_REM_W   = ROOT_W + 3;
  localparam int ALU_W      = (SQ_REM_W > DIV_REM_W) ? SQ_REM_W : DIV_REM_W;

endpackage

>>> hw/rtl/srl_divsqrt.sv
module srl_divsqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [srl_pkg::SUM_W-1:0]     sum,
  input  logic [srl_pkg::FRAME_W-1:0]   divisor,
  output logic                          done,
  output logic [srl_pkg::ROOT_W-1:0]    root
);

  typedef enum logic [2:0] {
    IDLE,
    SCALE,
    DIV,
    SQRT,
    FIN
  } state_t;

  state_t                         state;
  logic [srl_pkg::QUO_W-1:0]      quo;
  logic [srl_pkg::ALU_W-1:0]      rem;
  logic [srl_pkg::STEP_W-1:0]     step;

  logic [srl_pkg::ALU_W-1:0]      div_shift;
  logic [srl_pkg::ALU_W-1:0]      sqrt_shift;
  logic [srl_pkg::ALU_W-1:0]      alu_a;
  logic [srl_pkg::ALU_W-1:0]      alu_b;
  logic [srl_pkg::ALU_W:0]        alu_diff;
  logic                           alu_ge;

  // Partial remainders for one restoring divide step and one root step.
  assign div_shift  = {rem[srl_pkg::ALU_W-2:0], quo[srl_pkg::QUO_W-1]};
  assign sqrt_shift = {rem[srl_pkg::ALU_W-3:0], quo[srl_pkg::QUO_W-1 -: 2]};

  // The one shared subtract and compare unit serves both the divide and the root.
  always_comb begin
    if (state == SQRT) begin
      alu_a = sqrt_shift;
      alu_b = {{(srl_pkg::ALU_W - srl_pkg::ROOT_W - 2){1'b0}}, root, 2'b01};
    end else begin
      alu_a = div_shift;
      alu_b = {{(srl_pkg::ALU_W - srl_pkg::FRAME_W){1'b0}}, divisor};
    end
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[srl_pkg::ALU_W];
  assign done     = (state == FIN);

  // Sequencer: scale, one quotient bit a cycle, then one root bit a cycle, then finish.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            state <= SCALE;
          end
        end
        SCALE: begin
          quo   <= {{(srl_pkg::QUO_W - srl_pkg::SUM_W){1'b0}}, sum}
                   * srl_pkg::QUO_W'(srl_pkg::SAMPLE_STRIDE);
          rem   <= '0;
          step  <= srl_pkg::STEP_W'(srl_pkg::QUO_W - 1);
          state <= DIV;
        end
        DIV: begin
          quo <= {quo[srl_pkg::QUO_W-2:0], alu_ge};
          if (step == '0) begin
            // The root starts from zero and the remainder restarts for the root pass.
            root  <= '0;
            rem   <= '0;
            state <= SQRT;
            step  <= srl_pkg::STEP_W'(srl_pkg::ROOT_W - 1);
          end else begin
            rem  <= alu_ge ? alu_diff[srl_pkg::ALU_W-1:0] : div_shift;
            step <= step - 1'b1;
          end
        end
        SQRT: begin
          rem  <= alu_ge ? alu_diff[srl_pkg::ALU_W-1:0] : sqrt_shift;
          quo  <= {quo[srl_pkg::QUO_W-3:0], 2'b00};
          root <= {root[srl_pkg::ROOT_W-2:0], alu_ge};
          if (step == '0) begin
            state <= FIN;
          end else begin
            step <= step - 1'b1;
          end
        end
        FIN: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The root pass starts from a cleared root.
  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == SQRT && $past(state) == DIV) |-> (root == '0))
    else $error("root not cleared at start of root pass");

  a_done_after_root: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == SQRT)
    else $error("done without a finished root pass");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (state == SCALE) |-> $past(start))
    else $error("scale step entered without start");

endmodule

>>> hw/rtl/strided_rms_level.sv
// Channel  Direction  Handshake               Payload
// in       into block in_valid / in_stall     sample, last_sample
// out      from block out_valid / out_stall   rms_level, too_long
//
// While a buffer is summed, one item is taken every cycle.
// After the item marked last, the block stalls its input until the result is taken:
// a drain state and a scale step, one divide step and then one root step a cycle
// through a single shared subtractor, a finish state and the output state, which
// lasts for as long as out_stall holds the result.
// Reset (rst, synchronous) clears the sums and counters; the first item may follow at once.
module strided_rms_level (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [srl_pkg::SAMPLE_W-1:0]     sample,
  input  logic                             last_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [srl_pkg::LEVEL_W-1:0]      rms_level,
  output logic                             too_long
);

  typedef enum logic [1:0] {
    ACC,
    DRAIN,
    CALC,
    OUT
  } state_t;

  state_t                           state;
  logic [srl_pkg::SUM_W-1:0]        square_sum;
  logic [srl_pkg::FRAME_W-1:0]      frame_count;
  logic [srl_pkg::PHASE_W-1:0]      stride_phase;
  logic                             overflow_seen;
  logic [srl_pkg::SQ_W-1:0]         square;
  logic                             add_pend;

  logic                             in_take;
  logic                             counted;
  logic [srl_pkg::SAMPLE_W-1:0]     mag;
  logic [2*srl_pkg::SAMPLE_W-1:0]   mag_sq;
  logic                             eng_done;
  logic [srl_pkg::ROOT_W-1:0]       eng_root;

  assign in_stall  = (state != ACC);
  assign out_valid = (state == OUT);
  assign in_take   = in_valid && !in_stall;
  assign counted   = (frame_count < srl_pkg::FRAME_W'(srl_pkg::MAX_FRAMES));

  // Magnitude of the sample; full-scale negative maps to 32768.
  assign mag    = sample[srl_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign mag_sq = mag * mag;

  srl_divsqrt u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (state == DRAIN),
    .sum     (square_sum),
    .divisor (frame_count),
    .done    (eng_done),
    .root    (eng_root)
  );

  // Frame counting, squaring with a registered pipeline step, and the result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ACC;
      square_sum    <= '0;
      frame_count   <= '0;
      stride_phase  <= '0;
      overflow_seen <= 1'b0;
      add_pend      <= 1'b0;
    end else begin
      add_pend <= in_take && counted && (stride_phase == '0);
      if (add_pend) begin
        square_sum <= square_sum + {{(srl_pkg::SUM_W - srl_pkg::SQ_W){1'b0}}, square};
      end
      case (state)
        ACC: begin
          if (in_take) begin
            square <= mag_sq[srl_pkg::SQ_W-1:0];
            if (counted) begin
              frame_count <= frame_count + 1'b1;
              if (stride_phase == srl_pkg::PHASE_W'(srl_pkg::SAMPLE_STRIDE - 1)) begin
                stride_phase <= '0;
              end else begin
                stride_phase <= stride_phase + 1'b1;
              end
            end else begin
              overflow_seen <= 1'b1;
            end
            if (last_sample) begin
              state <= DRAIN;
            end
          end
        end
        DRAIN: begin
          state <= CALC;
        end
        CALC: begin
          if (eng_done) begin
            if (eng_root > srl_pkg::ROOT_W'(srl_pkg::FULL_SCALE)) begin
              rms_level <= srl_pkg::LEVEL_W'(srl_pkg::FULL_SCALE);
            end else begin
              rms_level <= eng_root[srl_pkg::LEVEL_W-1:0];
            end
            too_long <= overflow_seen;
            state    <= OUT;
          end
        end
        OUT: begin
          if (!out_stall) begin
            square_sum    <= '0;
            frame_count   <= '0;
            stride_phase  <= '0;
            overflow_seen <= 1'b0;
            state         <= ACC;
          end
        end
        default: begin
          state <= ACC;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= srl_pkg::FRAME_W'(srl_pkg::MAX_FRAMES))
    else $error("frame count beyond limit");

  a_pend_from_take: assert property (@(posedge clk) disable iff (rst)
    add_pend |-> $past(in_take))
    else $error("square added without an accepted item");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rms_level <= srl_pkg::LEVEL_W'(srl_pkg::FULL_SCALE)))
    else $error("level above full scale");

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> (state == CALC))
    else $error("divide and root finished outside the compute phase");

endmodule

>>> sim/strided_rms_level_chk.sv
`timescale 1ns / 1ps

module strided_rms_level_chk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [srl_pkg::SAMPLE_W-1:0] sample,
  input  logic                         last_sample,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [srl_pkg::LEVEL_W-1:0]  rms_level,
  input  logic                         too_long,
  output int                           errors,
  output int                           pending
);

  typedef struct packed {
    logic [srl_pkg::LEVEL_W-1:0] level;
    logic                        too_long;
  } level_t;

  // Levels predicted for finished buffers, oldest first.
  level_t      level_q[$];
  level_t      head;

  // Shadow copy of the accumulator state.
  logic [55:0] acc_sum;
  logic [16:0] acc_frames;
  int          stride_pos;
  logic        acc_over;
  int          mismatch_count;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Floor of the square root, one result bit per pass from the top.
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r[31:0];
  endfunction

  // Folds one accepted sample into the sums and forms the level on the last one.
  task automatic absorb_sample(input logic [srl_pkg::SAMPLE_W-1:0] s, input logic is_last);
    logic [15:0] mag;
    logic [63:0] mean;
    logic [63:0] lvl;
    level_t      res;
    mag = s[15] ? 16'(-s) : s;
    if (acc_frames < 17'(srl_pkg::MAX_FRAMES)) begin
      if (stride_pos == 0) acc_sum = 56'(acc_sum + 64'(mag) * 64'(mag));
      acc_frames = acc_frames + 17'd1;
      if (stride_pos + 1 >= srl_pkg::SAMPLE_STRIDE) stride_pos = 0;
      else stride_pos = stride_pos + 1;
    end else begin
      acc_over = 1'b1;
    end

    if (is_last) begin
      lvl = '0;
      if (acc_frames != '0) begin
        mean = 64'(acc_sum) * 64'(srl_pkg::SAMPLE_STRIDE) / 64'(acc_frames);
        lvl  = 64'(floor_sqrt(mean));
        if (lvl > 64'(srl_pkg::FULL_SCALE)) lvl = 64'(srl_pkg::FULL_SCALE);
      end
      res.level    = lvl[srl_pkg::LEVEL_W-1:0];
      res.too_long = acc_over;
      level_q.push_back(res);
      acc_sum    = '0;
      acc_frames = '0;
      stride_pos = 0;
      acc_over   = 1'b0;
    end
  endtask

  // Compare results against the oldest prediction, then take in new samples.
  always @(posedge clk) begin
    if (rst) begin
      level_q.delete();
      acc_sum    = '0;
      acc_frames = '0;
      stride_pos = 0;
      acc_over   = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (level_q.size() == 0) begin
          report_mismatch("unexpected result, rms_level", int'(rms_level), 0);
        end else begin
          head = level_q.pop_front();
          if (rms_level !== head.level)
            report_mismatch("rms_level", int'(rms_level), int'(head.level));
          if (too_long !== head.too_long)
            report_mismatch("too_long", int'(too_long), int'(head.too_long));
        end
      end
      if (in_valid && !in_stall) absorb_sample(sample, last_sample);
    end
    errors  <= mismatch_count;
    pending <= level_q.size();
  end

endmodule

>>> sim/strided_rms_level_tb.sv
`timescale 1ns / 1ps

module strided_rms_level_tb;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CALM_ITEMS   = 300;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [srl_pkg::SAMPLE_W-1:0] sample;
  logic                         last_sample;
  logic                         out_valid;
  logic                         out_stall;
  logic [srl_pkg::LEVEL_W-1:0]  rms_level;
  logic                         too_long;

  int   errors;
  int   pending;
  int   cycle_count = 0;
  int   sent = 0;
  logic idle_on;
  logic hold_req;

  strided_rms_level dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rms_level   (rms_level),
    .too_long    (too_long)
  );

  strided_rms_level_chk chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rms_level   (rms_level),
    .too_long    (too_long),
    .errors      (errors),
    .pending     (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("strided_rms_level test failed");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_stall <= 1'b0;
        while (hold_req) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one item, maybe after a gap, and returns at the edge that takes it.
  task automatic send_item(input logic [srl_pkg::SAMPLE_W-1:0] s, input logic is_last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    last_sample <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering items until every predicted level has come out.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Sample values weighted toward the extremes and toward small magnitudes.
  function automatic logic [srl_pkg::SAMPLE_W-1:0] pick_sample();
    logic [srl_pkg::SAMPLE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'(-16'sd1);
      3: v = 16'($urandom_range(0, 64)) - 16'd32;
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  // Random buffers: mostly short, some longer, some with one repeated value.
  task automatic run_random(input int target, input logic allow_idle);
    int                           len;
    logic                         repeated;
    logic [srl_pkg::SAMPLE_W-1:0] fixed_val;
    while (sent < target) begin
      len       = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      repeated  = ($urandom_range(0, 4) == 0);
      fixed_val = pick_sample();
      idle_on  <= allow_idle && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++) begin
        send_item(repeated ? fixed_val : pick_sample(), i == len - 1);
        sent++;
      end
      if ($urandom_range(0, 15) == 0) wait_results();
    end
  endtask

  initial begin
    in_valid    <= 1'b0;
    sample      <= '0;
    last_sample <= 1'b0;
    idle_on     <= 1'b0;
    hold_req    <= 1'b0;
    rst         <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-sample buffers at the extremes, then short mixed buffers.
    idle_on <= 1'b1;
    send_item(16'h0000, 1'b1);
    send_item(16'h8000, 1'b1);
    send_item(16'h7FFF, 1'b1);
    send_item(16'h0001, 1'b1);
    send_item(16'hFFFF, 1'b1);
    send_item(16'h4000, 1'b0);
    send_item(16'hC000, 1'b0);
    send_item(16'h0000, 1'b1);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b1);
    send_item(16'h0000, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0003, 1'b1);
    wait_results();

    run_random(RANDOM_ITEMS / 2, 1'b1);
    wait_results();

    // Long hold-off on the result side while several buffers keep coming.
    idle_on  <= 1'b0;
    hold_req <= 1'b1;
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < 3 + b; i++) send_item(pick_sample(), i == 2 + b);
    end
    wait_results();
    hold_req <= 1'b0;

    run_random(RANDOM_ITEMS - CALM_ITEMS, 1'b1);
    run_random(RANDOM_ITEMS, 1'b0);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("strided_rms_level test passed");
    end else begin
      $display("strided_rms_level test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/srl_pkg.sv
hw/rtl/srl_divsqrt.sv
hw/rtl/strided_rms_level.sv
sim/strided_rms_level_chk.sv
sim/strided_rms_level_tb.sv
